// File: rtl/neighbor_address_filter_defines.svh
// Assertion macros for the neighbor address filter RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef NEIGHBOR_ADDRESS_FILTER_DEFINES_SVH
`define NEIGHBOR_ADDRESS_FILTER_DEFINES_SVH

`ifndef SYNTH
// Check that prop holds in the same cycle as cond
`define NAF_ASSERT_IMPLY(name, a_clk, a_rst, cond, prop) \
  name: assert property (@(posedge a_clk) disable iff (a_rst) (cond) |-> (prop)) \
    else $error("neighbor_address_filter: same-cycle check failed");
// Check that prop holds in the cycle after cond
`define NAF_ASSERT_NEXT(name, a_clk, a_rst, cond, prop) \
  name: assert property (@(posedge a_clk) disable iff (a_rst) (cond) |=> (prop)) \
    else $error("neighbor_address_filter: next-cycle check failed");
`else
`define NAF_ASSERT_IMPLY(name, a_clk, a_rst, cond, prop)
`define NAF_ASSERT_NEXT(name, a_clk, a_rst, cond, prop)
`endif

`endif

// File: rtl/naf_pkg.sv
// Shared types, codes and mask functions of the neighbor address filter.
// No dependencies; used by every module of the block but naf_iface_mem.
package naf_pkg;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_ADD_IF  = 2'd1;
  localparam logic [1:0] OP_ADD_NET = 2'd2;

  // Address families
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BADPFX = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_FAMILY = 1'b1;

  // Longest prefixes per family
  localparam logic [7:0] V4_MAX_PFX = 8'd32;
  localparam logic [7:0] V6_MAX_PFX = 8'd128;

  // One stored subnet: network address already masked
  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
    logic [7:0]  prefix;
    logic        is_v6;
  } subnet_entry_t;

  // Leading-ones 128-bit mask; lengths of 128 and up give all ones
  function automatic logic [127:0] mask128(input logic [7:0] p);
    mask128 = ~({128{1'b1}} >> p);
  endfunction

  // Leading-ones 32-bit mask; lengths of 32 and up give all ones
  function automatic logic [31:0] mask32(input logic [7:0] p);
    mask32 = ~({32{1'b1}} >> p);
  endfunction

endpackage

// File: rtl/naf_iface_mem.sv
// Allowed-interface bit memory with a clearing sweep after reset.
// One write port, one registered read port; uses the shared assertion macros.
`include "neighbor_address_filter_defines.svh"

module naf_iface_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          set_en,
  input  logic [AW-1:0] set_addr,
  output logic          clearing
);

  logic          mem [DEPTH];
  logic          clr_active;
  logic [AW-1:0] clr_idx;

  assign clearing = clr_active;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == AW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // Clear during the sweep, otherwise set the allowed bit; register the read
  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_idx] <= 1'b0;
    end else if (set_en) begin
      mem[set_addr] <= 1'b1;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  `NAF_ASSERT_NEXT(a_clear_after_reset, clk, 1'b0, rst, clr_active && (clr_idx == '0))
  `NAF_ASSERT_IMPLY(a_no_set_while_clearing, clk, rst, clr_active, !set_en && !rd_en)

endmodule

// File: rtl/naf_subnet_mem.sv
// Subnet table memory: one write port, one registered read port.
// Entry layout comes from naf_pkg.
module naf_subnet_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  naf_pkg::subnet_entry_t wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output naf_pkg::subnet_entry_t rd_data
);

  naf_pkg::subnet_entry_t mem [DEPTH];

  // Write the new entry, register the scanned one
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/naf_match.sv
// Prefix compare of one query address against one stored subnet entry.
// Uses the mask functions and entry type of naf_pkg.
module naf_match (
  input  naf_pkg::subnet_entry_t entry,
  input  logic [1:0]             family,
  input  logic [63:0]            address_high,
  input  logic [63:0]            address_low,
  output logic                   hit
);

  logic [127:0] mask;
  logic [31:0]  mask_v4;
  logic         hit_v4;
  logic         hit_v6;

  // Build the entry's masks and compare within the same family only
  always_comb begin
    mask    = naf_pkg::mask128(entry.prefix);
    mask_v4 = naf_pkg::mask32(entry.prefix);
    hit_v4  = (family == naf_pkg::FAM_V4) && !entry.is_v6 &&
              ({32'b0, address_low[31:0] & mask_v4} == entry.lower);
    hit_v6  = (family == naf_pkg::FAM_V6) && entry.is_v6 &&
              ((address_high & mask[127:64]) == entry.upper) &&
              ((address_low & mask[63:0]) == entry.lower);
    hit     = hit_v4 || hit_v6;
  end

endmodule

// File: rtl/neighbor_address_filter.sv
// Top level of the neighbor address filter: control sequencer and registers.
// Depends on naf_pkg, naf_iface_mem, naf_subnet_mem, naf_match and the macro header.
`include "neighbor_address_filter_defines.svh"

// Neighbor event filter. Each input item is a query, an add-interface or an
// add-subnet operation (selected by s_tuser) and gives exactly one result item.
// After reset the allowed-interface memory is swept clear, and s_tready stays
// low during the sweep; configuration writes are taken at any time. The block
// works on one item at a time: a query scans the subnet memory one entry per
// cycle in S_SCAN, then loads its result into the output register in S_DONE;
// an add operation passes through S_EXEC and S_DONE. The next item is taken no
// earlier than the cycle after the previous result is loaded. The output
// register lets the next item be accepted while a result still waits on
// m_tready. A subnet table entry is stored with its host bits cleared; the
// table holds SUBNET_ENTRIES entries.
module neighbor_address_filter #(
  parameter int SUBNET_ENTRIES  = 16,
  parameter int INTERFACE_COUNT = 256
) (
  input  logic         clk,
  input  logic         rst,
  // s_tdata fields, low bit up: family[1:0], interface_index[9:2],
  // address_high[73:10], address_low[137:74], prefix_length[145:138], zero pad
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,
  // s_tuser fields: operation[1:0]
  input  logic [1:0]   s_tuser,
  // m_tdata fields, low bit up: accepted[0], status[2:1], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [2:0]   cfg_data
);

  localparam int IF_AW = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1;
  localparam int SN_AW = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;
  localparam int CNT_W = $clog2(SUBNET_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] subnet_count;
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [2:0]       filter_mode;
  logic [1:0]       selected_family;

  // Held item
  logic [1:0]  op_q;
  logic [1:0]  fam_q;
  logic [7:0]  ifx_q;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic [7:0]  pfx_q;

  // Result path
  logic       hit;
  logic       res_acc;
  logic [1:0] res_st;
  logic       out_acc;
  logic [1:0] out_st;

  logic                   accept;
  logic                   out_free;
  logic                   scan_more;
  logic                   scan_end;
  logic [IF_AW+7:0]       in_ifx_w;
  logic [IF_AW+7:0]       ifx_q_w;
  logic                   if_in_range;
  logic                   if_rd_data;
  logic                   if_set_en;
  logic                   if_clearing;
  logic                   bad_pfx;
  logic                   full;
  logic                   sn_we;
  logic                   match_hit;
  logic                   query_ok;
  logic [127:0]           wr_mask;
  logic [31:0]            wr_mask_v4;
  naf_pkg::subnet_entry_t wr_entry;
  naf_pkg::subnet_entry_t rd_entry;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && !if_clearing;
  assign out_free  = !m_tvalid || m_tready;
  assign scan_more = (scan_idx != subnet_count);
  assign scan_end  = !scan_more && !cmp_valid;
  assign m_tdata   = {5'b0, out_st, out_acc};

  assign in_ifx_w    = {{IF_AW{1'b0}}, s_tdata[9:2]};
  assign ifx_q_w     = {{IF_AW{1'b0}}, ifx_q};
  assign if_in_range = (ifx_q_w < (IF_AW + 8)'(INTERFACE_COUNT));
  assign if_set_en   = (state == S_EXEC) && (op_q == naf_pkg::OP_ADD_IF) && if_in_range;

  // Prefix check, table-full check and the masked entry to store
  always_comb begin
    case (fam_q)
      naf_pkg::FAM_V4: bad_pfx = (pfx_q > naf_pkg::V4_MAX_PFX);
      naf_pkg::FAM_V6: bad_pfx = (pfx_q > naf_pkg::V6_MAX_PFX);
      default:         bad_pfx = 1'b1;
    endcase
    full       = (subnet_count == CNT_W'(SUBNET_ENTRIES));
    sn_we      = (state == S_EXEC) && (op_q == naf_pkg::OP_ADD_NET) && !bad_pfx && !full;
    wr_mask    = naf_pkg::mask128(pfx_q);
    wr_mask_v4 = naf_pkg::mask32(pfx_q);
    wr_entry.prefix = pfx_q;
    if (fam_q == naf_pkg::FAM_V4) begin
      wr_entry.upper = 64'b0;
      wr_entry.lower = {32'b0, lo_q[31:0] & wr_mask_v4};
      wr_entry.is_v6 = 1'b0;
    end else begin
      wr_entry.upper = hi_q & wr_mask[127:64];
      wr_entry.lower = lo_q & wr_mask[63:0];
      wr_entry.is_v6 = 1'b1;
    end
  end

  // AND the enabled checks of a query
  always_comb begin
    query_ok = !(filter_mode[0] && (fam_q != selected_family)) &&
               !(filter_mode[1] && !(if_in_range && if_rd_data)) &&
               !(filter_mode[2] && !hit);
  end

  naf_iface_mem #(
    .DEPTH (INTERFACE_COUNT),
    .AW    (IF_AW)
  ) u_iface_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (in_ifx_w[IF_AW-1:0]),
    .rd_data  (if_rd_data),
    .set_en   (if_set_en),
    .set_addr (ifx_q_w[IF_AW-1:0]),
    .clearing (if_clearing)
  );

  naf_subnet_mem #(
    .DEPTH (SUBNET_ENTRIES),
    .AW    (SN_AW)
  ) u_subnet_mem (
    .clk     (clk),
    .wr_en   (sn_we),
    .wr_addr (subnet_count[SN_AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   ((state == S_SCAN) && scan_more),
    .rd_addr (scan_idx[SN_AW-1:0]),
    .rd_data (rd_entry)
  );

  naf_match u_match (
    .entry        (rd_entry),
    .family       (fam_q),
    .address_high (hi_q),
    .address_low  (lo_q),
    .hit          (match_hit)
  );

  // Sequencer, table fill count, output valid and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      subnet_count    <= '0;
      scan_idx        <= '0;
      cmp_valid       <= 1'b0;
      m_tvalid        <= 1'b0;
      filter_mode     <= 3'd0;
      selected_family <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          naf_pkg::CFG_MODE:   filter_mode     <= cfg_data;
          naf_pkg::CFG_FAMILY: selected_family <= cfg_data[1:0];
          default: ;
        endcase
      end
      // Raise valid when a result loads, drop it once taken
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state     <= (s_tuser == naf_pkg::OP_QUERY) ? S_SCAN : S_EXEC;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (sn_we) begin
            subnet_count <= subnet_count + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (scan_more) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          cmp_valid <= scan_more;
          if (scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the item, accumulate matches, form and hold results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= s_tuser;
      fam_q <= s_tdata[1:0];
      ifx_q <= s_tdata[9:2];
      hi_q  <= s_tdata[73:10];
      lo_q  <= s_tdata[137:74];
      pfx_q <= s_tdata[145:138];
      hit   <= 1'b0;
    end
    if ((state == S_SCAN) && cmp_valid && match_hit) begin
      hit <= 1'b1;
    end
    if ((state == S_SCAN) && scan_end) begin
      res_acc <= query_ok;
      res_st  <= naf_pkg::STAT_OK;
    end
    if (state == S_EXEC) begin
      res_acc <= 1'b0;
      if (op_q != naf_pkg::OP_ADD_NET) begin
        res_st <= naf_pkg::STAT_OK;
      end else if (bad_pfx) begin
        res_st <= naf_pkg::STAT_BADPFX;
      end else if (full) begin
        res_st <= naf_pkg::STAT_FULL;
      end else begin
        res_st <= naf_pkg::STAT_OK;
      end
    end
    if ((state == S_DONE) && out_free) begin
      out_acc <= res_acc;
      out_st  <= res_st;
    end
  end

  `NAF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE)
  `NAF_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, subnet_count <= CNT_W'(SUBNET_ENTRIES))
  `NAF_ASSERT_IMPLY(a_scan_bound, clk, rst, state == S_SCAN, scan_idx <= subnet_count)
  `NAF_ASSERT_NEXT(a_done_delivers, clk, rst, (state == S_DONE) && out_free, m_tvalid && (state == S_IDLE))

endmodule

// File: verif/tb.sv
// Self-checking bench for neighbor_address_filter: directed table, then random phases.
// Depends on naf_pkg and the neighbor_address_filter RTL; checks against its own predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import naf_pkg::*;

  localparam int          HALF_PERIOD   = 10;
  localparam int          TABLE_DEPTH   = 16;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          PHASES        = 9;
  localparam int          PER_PHASE     = 222;
  localparam int          TAIL_CYCLES   = 40;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [1:0]  FAM_OTHER2    = 2'd2;
  localparam logic [1:0]  FAM_OTHER3    = 2'd3;
  localparam logic [63:0] ALL_ONES      = '1;
  // Per-phase settings, phase 0 in the lowest bits
  localparam logic [26:0] PHASE_MODES    = {3'd7, 3'd3, 3'd5, 3'd6, 3'd2, 3'd1, 3'd4, 3'd7, 3'd0};
  localparam logic [17:0] PHASE_FAMILIES = {2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3, 2'd0};

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  fam;
    logic [7:0]  ifx;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  pfx;
  } filter_req_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status;
  } verdict_t;

  typedef struct {
    logic [2:0]  mode;
    logic [1:0]  sel;
    filter_req_t req;
    bit          typed;
    verdict_t    want;
  } step_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;
  logic         cfg_we;
  logic         cfg_index;
  logic [2:0]   cfg_data;

  // Predictor state
  logic [2:0]   mode_reg;
  logic [1:0]   family_reg;
  logic [255:0] iface_allowed;
  logic [127:0] net_addr [TABLE_DEPTH];
  logic [7:0]   net_len [TABLE_DEPTH];
  logic         net_v6 [TABLE_DEPTH];
  int           net_count;

  verdict_t     pending_verdicts[$];
  step_t        steps[$];
  int           mismatches;
  int           quiet_cycles;
  int           idle_style;

  neighbor_address_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Leading-ones mask of len bits over a field of width bits, right aligned
  function automatic logic [127:0] prefix_mask(input int len, input int width);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < width; b++) begin
      if (b < len) m[width - 1 - b] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [127:0] req_address(input filter_req_t r);
    if (r.fam == FAM_V6) return {r.hi, r.lo};
    return {96'b0, r.lo[31:0]};
  endfunction

  function automatic logic subnet_hit(input filter_req_t r);
    logic [127:0] m;
    logic         hit;
    hit = 1'b0;
    if (r.fam == FAM_V4 || r.fam == FAM_V6) begin
      for (int i = 0; i < net_count; i++) begin
        if (net_v6[i] == (r.fam == FAM_V6)) begin
          m = prefix_mask(net_len[i], net_v6[i] ? 128 : 32);
          if ((req_address(r) & m) == net_addr[i]) hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  // Compute the verdict of one item and advance the predictor state
  function automatic verdict_t filter_verdict(input filter_req_t r);
    verdict_t v;
    logic     pass;
    logic     bad;
    v = '0;
    case (r.op)
      OP_QUERY: begin
        pass = 1'b1;
        // mode bit 0: family, bit 1: interface, bit 2: subnet
        if (mode_reg[0] && r.fam != family_reg) pass = 1'b0;
        if (mode_reg[1] && !iface_allowed[r.ifx]) pass = 1'b0;
        if (mode_reg[2] && !subnet_hit(r)) pass = 1'b0;
        v.accepted = pass;
      end
      OP_ADD_IF: begin
        iface_allowed[r.ifx] = 1'b1;
      end
      OP_ADD_NET: begin
        if (r.fam == FAM_V4) bad = r.pfx > V4_MAX_PFX;
        else if (r.fam == FAM_V6) bad = r.pfx > V6_MAX_PFX;
        else bad = 1'b1;
        if (bad) begin
          v.status = STAT_BADPFX;
        end else if (net_count >= TABLE_DEPTH) begin
          v.status = STAT_FULL;
        end else begin
          // store the network address with host bits cleared
          net_addr[net_count] = req_address(r) &
                                prefix_mask(r.pfx, r.fam == FAM_V6 ? 128 : 32);
          net_len[net_count]  = r.pfx;
          net_v6[net_count]   = (r.fam == FAM_V6);
          net_count++;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic int gap_pct(input bit sender);
    case (idle_style)
      1: return sender ? 82 : 0;
      2: return sender ? 0 : 82;
      3: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [1:0] random_family(input int other_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < other_pct / 2) return FAM_OTHER2;
    if (r < other_pct) return FAM_OTHER3;
    return (r % 2 == 0) ? FAM_V4 : FAM_V6;
  endfunction

  // Mostly queries aimed at stored subnets, plus adds and a few unused codes
  function automatic filter_req_t random_req();
    filter_req_t  r;
    int           pick;
    int           k;
    logic [127:0] a;
    r.ifx = 8'($urandom_range(0, 255));
    r.hi  = {$urandom, $urandom};
    r.lo  = {$urandom, $urandom};
    r.pfx = 8'($urandom_range(0, 255));
    pick  = $urandom_range(0, 99);
    if (pick < 70) begin
      r.op  = OP_QUERY;
      r.fam = random_family(20);
      if (net_count > 0 && $urandom_range(0, 9) < 6) begin
        k     = $urandom_range(0, net_count - 1);
        r.fam = net_v6[k] ? FAM_V6 : FAM_V4;
        a     = ({r.hi, r.lo} & ~prefix_mask(net_len[k], net_v6[k] ? 128 : 32)) | net_addr[k];
        // sometimes disturb one bit, inside or outside the prefix
        if ($urandom_range(0, 4) == 0) a = a ^ (128'd1 << $urandom_range(0, 127));
        if (net_v6[k]) {r.hi, r.lo} = a;
        else r.lo[31:0] = a[31:0];
      end
    end else if (pick < 80) begin
      r.op  = OP_ADD_IF;
      r.fam = random_family(50);
    end else if (pick < 97) begin
      r.op  = OP_ADD_NET;
      r.fam = random_family(10);
      if ($urandom_range(0, 9) != 0) begin
        r.pfx = (r.fam == FAM_V6) ? 8'($urandom_range(16, 128)) : 8'($urandom_range(8, 32));
      end
    end else begin
      r.op  = OP_UNUSED;
      r.fam = random_family(50);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic add_step(input logic [2:0] mode, input logic [1:0] sel, input logic [1:0] op,
                          input logic [1:0] fam, input logic [7:0] ifx, input logic [63:0] hi,
                          input logic [63:0] lo, input logic [7:0] pfx, input bit typed,
                          input logic acc, input logic [1:0] st);
    step_t s;
    s.mode  = mode;
    s.sel   = sel;
    s.req   = '{op: op, fam: fam, ifx: ifx, hi: hi, lo: lo, pfx: pfx};
    s.typed = typed;
    s.want  = '{accepted: acc, status: st};
    steps.push_back(s);
  endtask

  // Present one item at a falling edge, hold it until taken, return at a falling edge
  task automatic drive_item(input filter_req_t r, input bit typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(0, 99) < gap_pct(1'b1)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.pfx, r.lo, r.hi, r.ifx, r.fam};
    s_tuser  <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = filter_verdict(r);
    pending_verdicts.push_back(typed ? want : v);
    @(negedge clk);
  endtask

  // Hold the sender until every pending verdict has come back
  task automatic wait_all_verdicts();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic program_filter(input logic [2:0] mode, input logic [1:0] sel);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= mode;
    @(negedge clk);
    cfg_index <= CFG_FAMILY;
    cfg_data  <= {1'b0, sel};
    @(negedge clk);
    cfg_we     <= 1'b0;
    mode_reg   = mode;
    family_reg = sel;
  endtask

  // Randomly stall the result side
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= gap_pct(1'b0));
  end

  // Compare each taken result with the oldest pending verdict
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, accepted", m_tdata[0], 0);
      end else begin
        if (m_tdata[0] !== pending_verdicts[0].accepted)
          report_mismatch("accepted", m_tdata[0], pending_verdicts[0].accepted);
        if (m_tdata[2:1] !== pending_verdicts[0].status)
          report_mismatch("status", m_tdata[2:1], pending_verdicts[0].status);
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    filter_req_t r;
    int          sent;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = OP_QUERY;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MODE;
    cfg_data      = '0;
    mode_reg      = '0;
    family_reg    = FAM_V4;
    iface_allowed = '0;
    net_count     = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    idle_style    = 0;

    // Reset state: every query accepted, adds give status ok
    add_step(0, 0, OP_QUERY,  FAM_OTHER3, 255, ALL_ONES, ALL_ONES, 255, 1, 1, STAT_OK);
    add_step(0, 0, OP_QUERY,  FAM_V4,     0,   0, 0, 0,               1, 1, STAT_OK);
    add_step(0, 0, OP_UNUSED, FAM_OTHER3, 255, ALL_ONES, ALL_ONES, 255, 1, 0, STAT_OK);
    add_step(0, 0, OP_ADD_IF, FAM_V4,     255, 0, 0, 0,               1, 0, STAT_OK);
    add_step(0, 0, OP_ADD_IF, FAM_V6,     0,   ALL_ONES, ALL_ONES, 255, 1, 0, STAT_OK);
    // Subnets of other families and overlong prefixes
    add_step(0, 0, OP_ADD_NET, FAM_OTHER2, 9, 0, 0, 8,                 1, 0, STAT_BADPFX);
    add_step(0, 0, OP_ADD_NET, FAM_OTHER3, 9, 0, 0, 0,                 1, 0, STAT_BADPFX);
    add_step(0, 0, OP_ADD_NET, FAM_V4, 9, 0, 64'hC0A8_0100, 33,        1, 0, STAT_BADPFX);
    add_step(0, 0, OP_ADD_NET, FAM_V6, 9, ALL_ONES, ALL_ONES, 129,     1, 0, STAT_BADPFX);
    add_step(0, 0, OP_ADD_NET, FAM_V6, 9, ALL_ONES, ALL_ONES, 255,     1, 0, STAT_BADPFX);
    // Valid subnets, host bits set in the added address
    add_step(0, 0, OP_ADD_NET, FAM_V4, 9, ALL_ONES, 64'hFFFF_FFFF_C0A8_01FF, 24, 1, 0, STAT_OK);
    add_step(0, 0, OP_ADD_NET, FAM_V6, 9, 64'h2001_0DB8_0000_0000, 0, 128,     1, 0, STAT_OK);
    add_step(0, 0, OP_ADD_NET, FAM_V6, 9, 64'h2001_0DB8_1234_0000, 64'hDEAD, 32, 1, 0, STAT_OK);
    add_step(0, 0, OP_ADD_NET, FAM_V4, 9, 0, 64'h0A00_0001, 32,               1, 0, STAT_OK);
    // Subnet check alone; other families never match
    add_step(4, 0, OP_QUERY, FAM_V4, 3, ALL_ONES, 64'h1234_5678_C0A8_0123, 0, 0, 0, STAT_OK);
    add_step(4, 0, OP_QUERY, FAM_OTHER2, 3, ALL_ONES, ALL_ONES, 0,            1, 0, STAT_OK);
    add_step(4, 0, OP_QUERY, FAM_OTHER3, 3, 0, 0, 0,                          1, 0, STAT_OK);
    add_step(4, 0, OP_QUERY, FAM_V6, 3, 64'h2001_0DB8_FFFF_FFFF, ALL_ONES, 0, 0, 0, STAT_OK);
    add_step(4, 0, OP_QUERY, FAM_V6, 3, 64'h2001_0DB9_0000_0000, 0, 0,        0, 0, STAT_OK);
    add_step(4, 0, OP_QUERY, FAM_V4, 3, 0, 64'h0A00_0002, 0,                  0, 0, STAT_OK);
    add_step(4, 0, OP_QUERY, FAM_V4, 3, 0, 64'h0A00_0001, 0,                  0, 0, STAT_OK);
    // Family and interface checks together
    add_step(3, 1, OP_QUERY, FAM_V6, 255, 0, 0, 0,                            0, 0, STAT_OK);
    add_step(3, 1, OP_QUERY, FAM_V6, 7, 0, 0, 0,                              0, 0, STAT_OK);
    add_step(3, 1, OP_QUERY, FAM_V4, 0, 0, 0, 0,                              0, 0, STAT_OK);
    // All checks on, selected family with no subnet possible
    add_step(7, 3, OP_QUERY, FAM_OTHER3, 255, ALL_ONES, ALL_ONES, 255,        1, 0, STAT_OK);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (steps[i]) begin
      if (steps[i].mode != mode_reg || steps[i].sel != family_reg) begin
        wait_all_verdicts();
        program_filter(steps[i].mode, steps[i].sel);
      end
      drive_item(steps[i].req, steps[i].typed, steps[i].want);
    end

    // Random phases, each with its own settings and idling
    for (int p = 0; p < PHASES; p++) begin
      wait_all_verdicts();
      program_filter(PHASE_MODES[p * 3 +: 3], PHASE_FAMILIES[p * 2 +: 2]);
      idle_style = p % 4;
      sent = 0;
      while (sent < PER_PHASE) begin
        r = random_req();
        drive_item(r, 1'b0, '0);
        if (r.op != OP_UNUSED) sent++;
        if ($urandom_range(0, 249) == 0) wait_all_verdicts();
      end
    end

    wait_all_verdicts();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
